// ===== src/ers_pkg.sv =====
package ers_pkg;

  // Depth of the sorted store, one cell per entry.
  localparam int unsigned Cells = 64;

  localparam int unsigned FeatW  = 16;
  localparam int unsigned DiffW  = FeatW + 1;
  localparam int unsigned SqW    = 2 * DiffW;
  localparam int unsigned DistW  = 48;
  localparam int unsigned IdentW = 16;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  // One entry of the sorted store.
  typedef struct packed {
    logic              valid;
    logic [DistW-1:0]  distance;
    logic [IdentW-1:0] ident;
  } entry_t;

  // Finished candidate handed from the distance pipeline to the store.
  typedef struct packed {
    logic [DistW-1:0]  distance;
    logic [IdentW-1:0] ident;
    logic              last_cand;
  } ins_req_t;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic drain;
  } cell_cmd_t;

endpackage

// ===== src/ers_dist.sv =====
module ers_dist (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic signed [ers_pkg::FeatW-1:0] query_feature_i,
  input  logic signed [ers_pkg::FeatW-1:0] candidate_feature_i,
  input  logic [ers_pkg::IdentW-1:0]      candidate_id_i,
  input  logic                            last_feature_i,
  input  logic                            last_candidate_i,
  output logic                            ins_valid_o,
  output ers_pkg::ins_req_t               ins_o
);

  // Stage 1: magnitude of the difference.
  logic                            s1_valid_q;
  logic [ers_pkg::DiffW-1:0]       s1_mag_q;
  logic [ers_pkg::IdentW-1:0]      s1_id_q;
  logic                            s1_lf_q, s1_lc_q;
  // Stage 2: square.
  logic                            s2_valid_q;
  logic [ers_pkg::SqW-1:0]         s2_sq_q;
  logic [ers_pkg::IdentW-1:0]      s2_id_q;
  logic                            s2_lf_q, s2_lc_q;
  // Stage 3: saturating accumulator.
  logic [ers_pkg::DistW-1:0]       acc_q, acc_d;
  logic                            ins_valid_q, ins_valid_d;
  ers_pkg::ins_req_t               ins_q, ins_d;

  logic signed [ers_pkg::DiffW-1:0] diff;
  logic [ers_pkg::DistW:0]          sum;
  logic [ers_pkg::DistW-1:0]        sat;

  assign diff = ers_pkg::DiffW'(query_feature_i) - ers_pkg::DiffW'(candidate_feature_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      ins_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      s1_valid_q  <= accept_i;
      s2_valid_q  <= s1_valid_q;
      ins_valid_q <= ins_valid_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_mag_q <= diff[ers_pkg::DiffW-1] ? ers_pkg::DiffW'(-diff) : ers_pkg::DiffW'(diff);
      s1_id_q  <= candidate_id_i;
      s1_lf_q  <= last_feature_i;
      s1_lc_q  <= last_candidate_i;
    end
    if (s1_valid_q) begin
      s2_sq_q <= s1_mag_q * s1_mag_q;
      s2_id_q <= s1_id_q;
      s2_lf_q <= s1_lf_q;
      s2_lc_q <= s1_lc_q;
    end
    ins_q <= ins_d;
  end

  always_comb begin
    sum         = {1'b0, acc_q} + (ers_pkg::DistW + 1)'(s2_sq_q);
    sat         = sum[ers_pkg::DistW] ? ers_pkg::DistMax : sum[ers_pkg::DistW-1:0];
    acc_d       = acc_q;
    ins_valid_d = 1'b0;
    ins_d       = ins_q;
    if (s2_valid_q) begin
      if (s2_lf_q) begin
        acc_d           = '0;
        ins_valid_d     = 1'b1;
        ins_d.distance  = sat;
        ins_d.ident     = s2_id_q;
        ins_d.last_cand = s2_lc_q;
      end else begin
        acc_d = sat;
      end
    end
  end

  assign ins_valid_o = ins_valid_q;
  assign ins_o       = ins_q;

endmodule

// ===== src/ers_cell.sv =====
module ers_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ers_pkg::cell_cmd_t          cmd_i,
  input  logic [ers_pkg::DistW-1:0]   new_dist_i,
  input  logic [ers_pkg::IdentW-1:0]  new_ident_i,
  input  ers_pkg::entry_t             prev_i,
  input  logic                        prev_takes_i,
  input  ers_pkg::entry_t             next_i,
  output ers_pkg::entry_t             entry_o,
  output logic                        takes_o
);

  ers_pkg::entry_t entry_q, entry_d;

  // The new entry ranks before this one; an empty cell always gives way.
  assign takes_o = !entry_q.valid || (new_dist_i < entry_q.distance) ||
                   ((new_dist_i == entry_q.distance) && (new_ident_i < entry_q.ident));

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.insert) begin
      if (prev_takes_i) begin
        entry_d = prev_i;
      end else if (takes_o) begin
        entry_d.valid    = 1'b1;
        entry_d.distance = new_dist_i;
        entry_d.ident    = new_ident_i;
      end
    end else if (cmd_i.drain) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== src/euclidean_rerank_sorter.sv =====
// Nearest-candidate ranking by squared Euclidean distance.
//
// Input channel: one request per cycle carries a query feature and the matching
// candidate feature (signed Q8.8), the candidate id and the last_feature and
// last_candidate marks. A request is taken when in_valid_i is high and in_stall_o
// is low. The squared differences are summed, saturating at 2^48-1.
// Once its last feature is taken, a candidate's distance passes the difference,
// square and accumulator registers to the sorted chain of 64 cells; every cell
// compares it with its own entry at once, so insertion never stalls the input
// and feature pairs flow at one per cycle while in_stall_o is low. When the
// final candidate of a query is taken, in_stall_o rises in the next cycle and
// stays high until the ranked list has been moved into the output register,
// longer while the receiver stalls. Draining starts after the final insertion.
// Output channel: each request is one ranked id with its distance, nearest
// first, rank_last_o on the final one and overflow_o set on all of them when
// more candidates arrived than the chain holds. While out_stall_i is high a
// valid output register holds its request and the chain waits.
// Reset empties the chain and the accumulator and clears the overflow mark.
module euclidean_rerank_sorter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [ers_pkg::FeatW-1:0] query_feature_i,
  input  logic signed [ers_pkg::FeatW-1:0] candidate_feature_i,
  input  logic [ers_pkg::IdentW-1:0]       candidate_id_i,
  input  logic                             last_feature_i,
  input  logic                             last_candidate_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ers_pkg::IdentW-1:0]       ranked_id_o,
  output logic [ers_pkg::DistW-1:0]        sq_distance_o,
  output logic                             rank_last_o,
  output logic                             overflow_o
);

  logic              accept;
  logic              ins_valid;
  ers_pkg::ins_req_t ins;
  ers_pkg::cell_cmd_t cmd;

  ers_pkg::entry_t entry [ers_pkg::Cells];
  logic            takes [ers_pkg::Cells];

  // Control state.
  logic flush_q, flush_d;      // final candidate taken, list not yet moved out
  logic draining_q, draining_d;
  logic ovf_q, ovf_d;
  logic out_valid_q, out_valid_d;
  logic pop, pop_last;

  // Output register payload.
  logic [ers_pkg::IdentW-1:0] out_id_q;
  logic [ers_pkg::DistW-1:0]  out_dist_q;
  logic                       out_last_q, out_ovf_q;

  assign in_stall_o = flush_q;
  assign accept     = in_valid_i && !flush_q;

  ers_dist u_dist (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .accept_i            (accept),
    .query_feature_i     (query_feature_i),
    .candidate_feature_i (candidate_feature_i),
    .candidate_id_i      (candidate_id_i),
    .last_feature_i      (last_feature_i),
    .last_candidate_i    (last_candidate_i),
    .ins_valid_o         (ins_valid),
    .ins_o               (ins)
  );

  // The chain shifts towards cell zero while the list is drained, one entry
  // per cycle, whenever the output register is free to take it.
  assign pop      = draining_q && entry[0].valid && (!out_valid_q || !out_stall_i);
  assign pop_last = pop && !entry[1].valid;

  assign cmd.insert = ins_valid;
  assign cmd.drain  = pop;

  for (genvar i = 0; i < ers_pkg::Cells; i++) begin : g_cell
    ers_pkg::entry_t prev_e, next_e;
    logic            prev_t;
    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_t = 1'b0;
    end else begin : g_mid
      assign prev_e = entry[i-1];
      assign prev_t = takes[i-1];
    end
    if (i == ers_pkg::Cells - 1) begin : g_end
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = entry[i+1];
    end
    ers_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .new_dist_i   (ins.distance),
      .new_ident_i  (ins.ident),
      .prev_i       (prev_e),
      .prev_takes_i (prev_t),
      .next_i       (next_e),
      .entry_o      (entry[i]),
      .takes_o      (takes[i])
    );
  end

  always_comb begin
    flush_d     = flush_q;
    draining_d  = draining_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    if (accept && last_feature_i && last_candidate_i) begin
      flush_d = 1'b1;
    end
    if (ins_valid) begin
      // A full chain means the last cell is occupied before this insertion.
      if (entry[ers_pkg::Cells-1].valid) begin
        ovf_d = 1'b1;
      end
      if (ins.last_cand) begin
        draining_d = 1'b1;
      end
    end
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_last) begin
      flush_d    = 1'b0;
      draining_d = 1'b0;
      ovf_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_q     <= 1'b0;
      draining_q  <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      flush_q     <= flush_d;
      draining_q  <= draining_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_id_q   <= entry[0].ident;
      out_dist_q <= entry[0].distance;
      out_last_q <= !entry[1].valid;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ranked_id_o   = out_id_q;
  assign sq_distance_o = out_dist_q;
  assign rank_last_o   = out_last_q;
  assign overflow_o    = out_ovf_q;

endmodule

// ===== src/ers_checker.sv =====
module ers_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic signed [ers_pkg::FeatW-1:0] query_feature_i,
  input logic signed [ers_pkg::FeatW-1:0] candidate_feature_i,
  input logic [ers_pkg::IdentW-1:0]       candidate_id_i,
  input logic                             last_feature_i,
  input logic                             last_candidate_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [ers_pkg::IdentW-1:0]       ranked_id_o,
  input logic [ers_pkg::DistW-1:0]        sq_distance_o,
  input logic                             rank_last_o,
  input logic                             overflow_o
);

  // A stalled result request holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ranked_id_o) &&
      $stable(sq_distance_o) && $stable(rank_last_o) && $stable(overflow_o))
    else $error("stalled result changed");

  // The final candidate of a query closes the input until the list is out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_feature_i && last_candidate_i |=> in_stall_o)
    else $error("input not stalled after final candidate");

  // Results before the end of a list appear only while the input is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rank_last_o |-> in_stall_o)
    else $error("list result while input open");

  // The overflow mark is the same on every result of one list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !rank_last_o |=>
      !out_valid_o || (overflow_o == $past(overflow_o)))
    else $error("overflow mark changed within a list");

endmodule

bind euclidean_rerank_sorter ers_checker u_ers_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

// Testbench for euclidean_rerank_sorter.
//
// An initial block fills a queue of feature pair requests. The queue holds a
// directed opening, one long candidate and then random queries. A driver
// at the falling edge offers the requests. A monitor at the rising edge sees
// each request that is taken. It runs it through a local ranking model, which
// keeps its own sorted store, and so builds a queue of ranked results that are
// due. Each result that leaves the block is checked field by field against the
// oldest entry in that queue.
module tb;

  localparam int unsigned FeatW  = ers_pkg::FeatW;
  localparam int unsigned IdentW = ers_pkg::IdentW;
  localparam int unsigned DistW  = ers_pkg::DistW;
  localparam int unsigned Cells  = ers_pkg::Cells;
  localparam logic [DistW-1:0] DistMax = ers_pkg::DistMax;

  localparam int unsigned IdlePct     = 13;
  localparam int unsigned RandomPairs = 230;
  // Pairs of the long candidate, all at the largest difference.
  localparam int unsigned LongPairs   = 24;
  localparam int unsigned CalmPairs   = 120;
  localparam int unsigned HoldAfter   = 40;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 1000000;

  // One feature pair request, as it appears on the input ports.
  typedef struct packed {
    logic [FeatW-1:0]  query;
    logic [FeatW-1:0]  cand;
    logic [IdentW-1:0] ident;
    logic              last_feat;
    logic              last_cand;
  } pair_t;

  // One ranked result, as it appears on the output ports.
  typedef struct packed {
    logic [IdentW-1:0] ident;
    logic [DistW-1:0]  distance;
    logic              last;
    logic              ovf;
  } ranked_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [FeatW-1:0] query_feature_i = '0;
  logic signed [FeatW-1:0] candidate_feature_i = '0;
  logic [IdentW-1:0]       candidate_id_i = '0;
  logic                    last_feature_i = 1'b0;
  logic                    last_candidate_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [IdentW-1:0]       ranked_id_o;
  logic [DistW-1:0]        sq_distance_o;
  logic                    rank_last_o;
  logic                    overflow_o;

  euclidean_rerank_sorter u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .query_feature_i     (query_feature_i),
    .candidate_feature_i (candidate_feature_i),
    .candidate_id_i      (candidate_id_i),
    .last_feature_i      (last_feature_i),
    .last_candidate_i    (last_candidate_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .ranked_id_o         (ranked_id_o),
    .sq_distance_o       (sq_distance_o),
    .rank_last_o         (rank_last_o),
    .overflow_o          (overflow_o)
  );

  // Requests not yet taken by the block, and ranked results not yet seen.
  pair_t   feature_pairs[$];
  ranked_t ranked_due[$];

  // Local copy of the ranking state: running distance, sorted store, overflow.
  logic [DistW-1:0]  run_dist = '0;
  logic [DistW-1:0]  kept_dist [Cells];
  logic [IdentW-1:0] kept_ident [Cells];
  int unsigned       kept_count = 0;
  logic              kept_overflow = 1'b0;

  int unsigned pairs_taken = 0;
  int unsigned results_checked = 0;
  int unsigned queries_ranked = 0;
  int unsigned overflow_results = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned calm_from = 32'hFFFF_FFFF;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        pair_taken = 1'b0;
  logic        calm;

  // Within the calm window neither side idles at random, so the block sees back-to-back
  // traffic for a long stretch.
  assign calm = (pairs_taken >= calm_from) && (pairs_taken < calm_from + CalmPairs);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Ranking model. Each taken request adds its squared difference to the
  // running distance, which saturates at the top of its range. A candidate's
  // last feature puts the candidate into the sorted store. The final candidate
  // of a query releases the whole store as ranked results.
  task automatic absorb_pair(input pair_t p);
    logic [FeatW:0]   diff;
    logic [FeatW:0]   mag;
    logic [63:0]      sum;
    logic [DistW-1:0] d;
    int unsigned      n;
    int unsigned      pos;
    ranked_t          r;
    diff = {p.query[FeatW-1], p.query} - {p.cand[FeatW-1], p.cand};
    mag  = diff[FeatW] ? -diff : diff;
    sum  = {16'b0, run_dist} + {47'b0, mag} * {47'b0, mag};
    if (sum > {16'b0, DistMax}) begin
      sum = {16'b0, DistMax};
    end
    run_dist = sum[DistW-1:0];
    if (!p.last_feat) begin
      // A last_candidate mark without last_feature has no effect.
      return;
    end
    d = run_dist;
    run_dist = '0;
    n = kept_count;
    pos = 0;
    // Ascending distance; equal distances in ascending id order, and an
    // entry equal in both goes behind the ones already stored.
    while (pos < n && !((d < kept_dist[pos]) ||
                        (d == kept_dist[pos] && p.ident < kept_ident[pos]))) begin
      pos++;
    end
    if (n >= Cells) begin
      // A full store keeps the nearest entries and remembers the overflow.
      kept_overflow = 1'b1;
      n = (pos >= Cells) ? Cells : Cells - 1;
    end
    if (pos < Cells) begin
      for (int unsigned i = n; i > pos; i--) begin
        kept_dist[i]  = kept_dist[i-1];
        kept_ident[i] = kept_ident[i-1];
      end
      kept_dist[pos]  = d;
      kept_ident[pos] = p.ident;
      if (kept_count < Cells) begin
        kept_count = n + 1;
      end
    end
    if (!p.last_cand) begin
      return;
    end
    for (int unsigned k = 0; k < kept_count; k++) begin
      r.ident    = kept_ident[k];
      r.distance = kept_dist[k];
      r.last     = (k + 1 == kept_count);
      r.ovf      = kept_overflow;
      ranked_due.push_back(r);
    end
    queries_ranked++;
    kept_count = 0;
    kept_overflow = 1'b0;
  endtask

  task automatic push_pair(input logic [FeatW-1:0] q, input logic [FeatW-1:0] c,
                           input logic [IdentW-1:0] id, input logic lf, input logic lc);
    pair_t p;
    p.query     = q;
    p.cand      = c;
    p.ident     = id;
    p.last_feat = lf;
    p.last_cand = lc;
    feature_pairs.push_back(p);
  endtask

  // Sender: a request stays on the ports until it is taken; otherwise the
  // next one is offered unless the sender idles this cycle.
  always @(negedge clk_i) begin
    logic  offer;
    pair_t nxt;
    if (rst_ni && !(in_valid_i && !pair_taken)) begin
      offer = (feature_pairs.size() != 0) && (calm || $urandom_range(99) >= IdlePct);
      if (offer) begin
        nxt = feature_pairs[0];
        query_feature_i     <= nxt.query;
        candidate_feature_i <= nxt.cand;
        candidate_id_i      <= nxt.ident;
        last_feature_i      <= nxt.last_feat;
        last_candidate_i    <= nxt.last_cand;
      end
      in_valid_i <= offer;
    end
    pair_taken = 1'b0;
  end

  // Receiver: random stalls, and once a long hold-off so that the block has to
  // keep its list and stall its input while the sender goes on offering.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && results_checked >= HoldAfter) begin
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  // Monitor for both channels, sampling the values that stood before the edge.
  always @(posedge clk_i) begin
    ranked_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      absorb_pair({query_feature_i, candidate_feature_i, candidate_id_i,
                   last_feature_i, last_candidate_i});
      void'(feature_pairs.pop_front());
      pair_taken = 1'b1;
      pairs_taken++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (ranked_due.size() == 0) begin
        $display("%0t: result id %h distance %h arrived with nothing expected",
                 $time, ranked_id_o, sq_distance_o);
        errors++;
      end else begin
        want = ranked_due.pop_front();
        if (ranked_id_o !== want.ident) begin
          $display("%0t: ranked_id expected %h, got %h", $time, want.ident, ranked_id_o);
          errors++;
        end
        if (sq_distance_o !== want.distance) begin
          $display("%0t: sq_distance expected %h, got %h", $time, want.distance,
                   sq_distance_o);
          errors++;
        end
        if (rank_last_o !== want.last) begin
          $display("%0t: rank_last expected %b, got %b", $time, want.last, rank_last_o);
          errors++;
        end
        if (overflow_o !== want.ovf) begin
          $display("%0t: overflow expected %b, got %b", $time, want.ovf, overflow_o);
          errors++;
        end
        if (want.ovf) begin
          overflow_results++;
        end
      end
      results_checked++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d requests and %0d results outstanding",
               cycle_count, feature_pairs.size(), ranked_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned random_pairs;
    int unsigned query_idx;
    int unsigned ncand;
    int unsigned nfeat;
    logic        wide_store;
    logic        narrow;
    logic [IdentW-1:0] id;
    logic [FeatW-1:0]  q;
    logic [FeatW-1:0]  c;

    // Directed query: field extremes, a largest-id and a zero-id candidate,
    // distance ties broken by id, a duplicate id and a stray last_candidate.
    push_pair(16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b0, 1'b0);
    push_pair(16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b1, 1'b0);
    push_pair(16'sh0000, 16'sh0000, 16'h0000, 1'b1, 1'b0);
    push_pair(16'sh0005, 16'sh0003, 16'h0007, 1'b0, 1'b1);
    push_pair(16'sh0000, 16'sh0000, 16'h0007, 1'b1, 1'b0);
    push_pair(16'sh0064, 16'sh0064, 16'h0009, 1'b1, 1'b0);
    push_pair(16'shFFFF, 16'shFFFF, 16'h0003, 1'b1, 1'b0);
    push_pair(16'sh7F00, 16'sh7F00, 16'h0009, 1'b1, 1'b0);
    push_pair(16'shFF00, 16'sh0100, 16'h8000, 1'b1, 1'b1);
    // A query of one candidate and one feature.
    push_pair(16'sh7FFF, 16'sh7FFF, 16'h0001, 1'b1, 1'b1);
    // A long candidate at the largest difference builds a large distance,
    // then a near one must rank ahead of it.
    for (int unsigned i = 0; i < LongPairs; i++) begin
      push_pair((i % 2) ? 16'sh8000 : 16'sh7FFF, (i % 2) ? 16'sh7FFF : 16'sh8000,
                16'h1234, i == LongPairs - 1, 1'b0);
    end
    push_pair(16'sh0001, 16'sh0000, 16'h00AA, 1'b1, 1'b1);
    calm_from = feature_pairs.size() + 40;

    // Random queries. Most are short; two have more candidates than the store
    // holds, with narrow values and ids so that ties and duplicates are common.
    random_pairs = 0;
    query_idx = 0;
    while (random_pairs < RandomPairs) begin
      wide_store = (query_idx == 0) || (query_idx == 3);
      ncand = wide_store ? $urandom_range(Cells + 8, Cells + 1) : $urandom_range(12, 1);
      narrow = wide_store || ($urandom_range(1) == 0);
      for (int unsigned k = 0; k < ncand; k++) begin
        nfeat = wide_store ? 1 : $urandom_range(5, 1);
        id = narrow ? IdentW'($urandom_range(7)) : IdentW'($urandom);
        for (int unsigned f = 0; f < nfeat; f++) begin
          q = narrow ? FeatW'(int'($urandom_range(6)) - 3) : FeatW'($urandom);
          c = narrow ? FeatW'(int'($urandom_range(6)) - 3) : FeatW'($urandom);
          // Mid-candidate pairs sometimes carry a stray last_candidate mark.
          push_pair(q, c, id, f == nfeat - 1,
                    (f == nfeat - 1) ? (k == ncand - 1) : ($urandom_range(3) == 0));
          random_pairs++;
        end
      end
      query_idx++;
    end

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (feature_pairs.size() != 0 || ranked_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d feature pairs through %0d ranked queries, including a long candidate",
             pairs_taken, queries_ranked);
    $display("and full stores; %0d ranked results checked, %0d of them flagged overflow.",
             results_checked, overflow_results);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
